### src/fwspt_pkg.sv
// Shared types, codes and default sizes for the working-set page tracker.
`timescale 1ns / 1ps
`default_nettype none

package fwspt_pkg;

	// Default storage sizes.
	localparam int RING_DEPTH_DEF  = 64;
	localparam int TABLE_DEPTH_DEF = 1024;

	// Fixed field geometry.
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_W     = 52;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 7;

	// Operation codes.
	localparam logic [1:0] OP_REGISTER  = 2'd0;
	localparam logic [1:0] OP_SET_PERMS = 2'd1;
	localparam logic [1:0] OP_FAULT     = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_TABLE_FULL = 2'd1;
	localparam logic [1:0] STAT_OPEN_FAULT = 2'd2;
	localparam logic [1:0] STAT_UNKNOWN    = 2'd3;

	// Permission values.
	localparam logic [2:0] PERM_NONE = 3'b000;
	localparam logic [2:0] PERM_RW   = 3'b011;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE = 8'd1;

	// Configuration reset values.
	localparam logic [6:0] RING_SIZE_RST = 7'd64;

	// One input word.
	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] address;
		logic [2:0]  new_perms;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [1:0]        status;
		logic              apply_valid;
		logic [PAGE_W-1:0] apply_page;
		logic [2:0]        apply_perms;
		logic              evict_valid;
		logic [PAGE_W-1:0] evict_page;
		logic              trace_valid;
		logic [PAGE_W-1:0] trace_page;
	} result_t;

	// One page table entry.
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
		logic [2:0]        perms;
		logic              open;
	} tbl_entry_t;

endpackage

`default_nettype wire

### src/fifo_working_set_page_tracker.sv
// Sequencing: words with no table lookup go from acceptance through S_EMIT to the output register;
// a table op first probes hashed slots in S_LOOK, one slot per probe; a fault that opens a page
// adds the S_FIN write-back, and when it evicts also the S_RINGRD ring read and S_EVLOOK probes
// for the evicted page. Flow: a new word is taken only once the last result is loaded into the
// output register, so output stalls hold off further words.
// Reset: a clearing pass sweeps the page table, words are held off meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module fifo_working_set_page_tracker #(
	parameter int RING_DEPTH  = fwspt_pkg::RING_DEPTH_DEF,
	parameter int TABLE_DEPTH = fwspt_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire fwspt_pkg::item_t                 item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output fwspt_pkg::result_t                    result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fwspt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fwspt_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int PAGE_W = fwspt_pkg::PAGE_W;
	localparam int TIDX_W = $clog2(TABLE_DEPTH);
	localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int RCNT_W = $clog2(RING_DEPTH + 1);
	localparam int SZ_W   = (RCNT_W > 7) ? RCNT_W : 7;
	localparam int NCHUNK = (PAGE_W + TIDX_W - 1) / TIDX_W;
	localparam int HPAD_W = NCHUNK * TIDX_W;
	localparam int TE_W   = $bits(fwspt_pkg::tbl_entry_t);

	localparam logic [TIDX_W-1:0] TLAST = TIDX_W'(TABLE_DEPTH - 1);

	// Sequencer state codes.
	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_LOOK   = 3'd2;
	localparam logic [2:0] S_RINGRD = 3'd3;
	localparam logic [2:0] S_EVLOOK = 3'd4;
	localparam logic [2:0] S_FIN    = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	// Control registers.
	logic [2:0]        state_q, state_d;
	logic [TIDX_W-1:0] ptr_q, ptr_d;
	logic [TCNT_W-1:0] probes_q, probes_d;
	logic [TCNT_W-1:0] tcount_q, tcount_d;
	logic [RIDX_W-1:0] ring_index_q, ring_index_d;
	logic [RCNT_W-1:0] ring_fill_q, ring_fill_d;
	logic [6:0]        ring_size_q;
	logic              trace_q;
	logic              out_valid_q;

	// Payload registers.
	logic [1:0]          op_q, op_d;
	logic [PAGE_W-1:0]   page_q, page_d;
	logic [2:0]          perms_q, perms_d;
	logic [TIDX_W-1:0]   e_addr_q, e_addr_d;
	logic [2:0]          e_perms_q, e_perms_d;
	logic [RIDX_W-1:0]   ridx_q, ridx_d;
	fwspt_pkg::result_t  res_q, res_d;
	fwspt_pkg::result_t  out_q;

	// Memory ports.
	logic                   tbl_we;
	logic [TIDX_W-1:0]      tbl_waddr;
	fwspt_pkg::tbl_entry_t  tbl_wdata;
	logic [TIDX_W-1:0]      tbl_raddr;
	logic [TE_W-1:0]        tbl_rdata_raw;
	fwspt_pkg::tbl_entry_t  tbl_rd;
	logic                   ring_we;
	logic [PAGE_W-1:0]      ring_rdata;

	// Misc combinational signals.
	logic [PAGE_W-1:0] item_page;
	logic [TIDX_W-1:0] item_hash;
	logic [TIDX_W-1:0] evict_hash;
	logic [TIDX_W-1:0] ptr_next;
	logic              exhausted;
	logic              hit_item;
	logic              hit_evict;
	logic [SZ_W-1:0]   eff_size;
	logic [SZ_W-1:0]   size_raw;
	logic [RIDX_W-1:0] cur_idx;
	logic [SZ_W-1:0]   idx_inc;
	logic              slot_valid;
	logic              load_out;

	// XOR-fold a page number into a table index, then reduce below the table depth.
	function automatic logic [TIDX_W-1:0] page_hash(input logic [PAGE_W-1:0] pg);
		logic [HPAD_W-1:0] padded;
		logic [TIDX_W-1:0] h;
		padded = HPAD_W'(pg);
		h = '0;
		for (int c = 0; c < NCHUNK; c++) begin
			h = h ^ padded[c*TIDX_W +: TIDX_W];
		end
		if (TCNT_W'(h) >= TCNT_W'(TABLE_DEPTH)) begin
			h = h - TIDX_W'(TABLE_DEPTH);
		end
		return h;
	endfunction

	// Page table: valid, page, stored permissions and open flag per slot.
	fwspt_ram #(
		.WIDTH(TE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(tbl_waddr),
		.wdata(tbl_wdata),
		.raddr(tbl_raddr),
		.rdata(tbl_rdata_raw)
	);

	// Ring of open pages; slots below the fill mark are valid.
	fwspt_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ridx_q),
		.wdata(page_q),
		.raddr(cur_idx),
		.rdata(ring_rdata)
	);

	assign tbl_rd     = fwspt_pkg::tbl_entry_t'(tbl_rdata_raw);
	assign item_page  = item.address[fwspt_pkg::PAGE_SHIFT +: PAGE_W];
	assign item_hash  = page_hash(item_page);
	assign evict_hash = page_hash(ring_rdata);
	assign ptr_next   = (ptr_q == TLAST) ? '0 : ptr_q + 1'b1;
	assign exhausted  = (probes_q == TCNT_W'(TABLE_DEPTH));
	assign hit_item   = tbl_rd.valid && (tbl_rd.page == page_q);
	assign hit_evict  = tbl_rd.valid && (tbl_rd.page == res_q.evict_page);

	// Effective ring size, clamped to 1..RING_DEPTH, and the slot used by the next fault.
	assign size_raw = SZ_W'(ring_size_q);
	always_comb begin
		eff_size = size_raw;
		if (size_raw == '0) begin
			eff_size = SZ_W'(1);
		end else if (size_raw > SZ_W'(RING_DEPTH)) begin
			eff_size = SZ_W'(RING_DEPTH);
		end
	end
	assign cur_idx    = (SZ_W'(ring_index_q) >= eff_size) ? '0 : ring_index_q;
	assign slot_valid = (RCNT_W'(cur_idx) < ring_fill_q);
	assign idx_inc    = SZ_W'(ridx_q) + SZ_W'(1);

	assign load_out     = (state_q == S_EMIT) && (!out_valid_q || !result_stall);
	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign cfg_ready    = 1'b1;

	// Sequencer: table probes, ring read, eviction and write-back.
	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		probes_d     = probes_q;
		tcount_d     = tcount_q;
		ring_index_d = ring_index_q;
		ring_fill_d  = ring_fill_q;
		op_d         = op_q;
		page_d       = page_q;
		perms_d      = perms_q;
		e_addr_d     = e_addr_q;
		e_perms_d    = e_perms_q;
		ridx_d       = ridx_q;
		res_d        = res_q;
		tbl_we       = 1'b0;
		tbl_waddr    = ptr_q;
		tbl_wdata    = '0;
		tbl_raddr    = ptr_next;
		ring_we      = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				// Sweep every slot to invalid.
				tbl_we = 1'b1;
				ptr_d  = ptr_next;
				if (ptr_q == TLAST) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				tbl_raddr = item_hash;
				if (item_valid) begin
					op_d     = item.operation;
					page_d   = item_page;
					perms_d  = item.new_perms;
					ptr_d    = item_hash;
					probes_d = TCNT_W'(1);
					res_d    = '0;
					state_d  = S_EMIT;
					case (item.operation)
						fwspt_pkg::OP_REGISTER: begin
							if (trace_q) begin
								state_d = S_LOOK;
							end
						end
						fwspt_pkg::OP_SET_PERMS: begin
							state_d = S_LOOK;
						end
						fwspt_pkg::OP_FAULT: begin
							res_d.trace_valid = 1'b1;
							res_d.trace_page  = item_page;
							if (trace_q) begin
								state_d = S_LOOK;
							end else begin
								res_d.apply_valid = 1'b1;
								res_d.apply_page  = item_page;
								res_d.apply_perms = fwspt_pkg::PERM_RW;
							end
						end
						default: begin
							state_d = S_EMIT;
						end
					endcase
				end
			end

			S_LOOK: begin
				if (!hit_item && tbl_rd.valid && !exhausted) begin
					// Occupied by another page: go on to the next slot.
					ptr_d    = ptr_next;
					probes_d = probes_q + 1'b1;
				end else begin
					state_d = S_EMIT;
					case (op_q)
						fwspt_pkg::OP_REGISTER: begin
							if (hit_item || !tbl_rd.valid) begin
								res_d.apply_valid = 1'b1;
								res_d.apply_page  = page_q;
								res_d.apply_perms = fwspt_pkg::PERM_NONE;
								tbl_wdata.valid   = 1'b1;
								tbl_wdata.page    = page_q;
								tbl_wdata.perms   = fwspt_pkg::PERM_RW;
								tbl_wdata.open    = 1'b0;
								if (!hit_item) begin
									tbl_we   = 1'b1;
									tcount_d = tcount_q + 1'b1;
								end else if (!tbl_rd.open) begin
									tbl_we = 1'b1;
								end
							end else begin
								res_d.status = fwspt_pkg::STAT_TABLE_FULL;
							end
						end
						fwspt_pkg::OP_SET_PERMS: begin
							if (hit_item) begin
								tbl_we          = 1'b1;
								tbl_wdata       = tbl_rd;
								tbl_wdata.perms = perms_q;
								if (tbl_rd.open) begin
									res_d.apply_valid = 1'b1;
									res_d.apply_page  = page_q;
									res_d.apply_perms = perms_q;
								end
							end else begin
								res_d.status = fwspt_pkg::STAT_UNKNOWN;
							end
						end
						fwspt_pkg::OP_FAULT: begin
							if (!hit_item) begin
								res_d.status = fwspt_pkg::STAT_UNKNOWN;
							end else if (tbl_rd.open) begin
								res_d.status = fwspt_pkg::STAT_OPEN_FAULT;
							end else begin
								e_addr_d  = ptr_q;
								e_perms_d = tbl_rd.perms;
								ridx_d    = cur_idx;
								// The ring slot is read at cur_idx in this cycle.
								state_d   = slot_valid ? S_RINGRD : S_FIN;
							end
						end
						default: begin
							state_d = S_EMIT;
						end
					endcase
				end
			end

			S_RINGRD: begin
				// Evicted page arrives; start probing the table for it.
				res_d.evict_valid = 1'b1;
				res_d.evict_page  = ring_rdata;
				tbl_raddr         = evict_hash;
				ptr_d             = evict_hash;
				probes_d          = TCNT_W'(1);
				state_d           = S_EVLOOK;
			end

			S_EVLOOK: begin
				if (hit_evict) begin
					tbl_we         = 1'b1;
					tbl_wdata      = tbl_rd;
					tbl_wdata.open = 1'b0;
					state_d        = S_FIN;
				end else if (!tbl_rd.valid || exhausted) begin
					state_d = S_FIN;
				end else begin
					ptr_d    = ptr_next;
					probes_d = probes_q + 1'b1;
				end
			end

			S_FIN: begin
				// Open the faulting page and put it in the ring.
				tbl_we          = 1'b1;
				tbl_waddr       = e_addr_q;
				tbl_wdata.valid = 1'b1;
				tbl_wdata.page  = page_q;
				tbl_wdata.perms = e_perms_q;
				tbl_wdata.open  = 1'b1;
				ring_we         = 1'b1;
				if (RCNT_W'(ridx_q) == ring_fill_q) begin
					ring_fill_d = ring_fill_q + 1'b1;
				end
				ring_index_d      = (idx_inc >= eff_size) ? '0 : RIDX_W'(idx_inc);
				res_d.apply_valid = 1'b1;
				res_d.apply_page  = page_q;
				res_d.apply_perms = e_perms_q;
				state_d           = S_EMIT;
			end

			S_EMIT: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			ptr_q        <= '0;
			probes_q     <= '0;
			tcount_q     <= '0;
			ring_index_q <= '0;
			ring_fill_q  <= '0;
		end else begin
			state_q      <= state_d;
			ptr_q        <= ptr_d;
			probes_q     <= probes_d;
			tcount_q     <= tcount_d;
			ring_index_q <= ring_index_d;
			ring_fill_q  <= ring_fill_d;
		end
	end

	// Per-word working registers.
	always_ff @(posedge clk) begin
		op_q      <= op_d;
		page_q    <= page_d;
		perms_q   <= perms_d;
		e_addr_q  <= e_addr_d;
		e_perms_q <= e_perms_d;
		ridx_q    <= ridx_d;
		res_q     <= res_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= res_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= fwspt_pkg::RING_SIZE_RST;
			trace_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fwspt_pkg::REG_RING_SIZE: begin
					ring_size_q <= cfg_data[6:0];
				end
				fwspt_pkg::REG_TRACE_ENABLE: begin
					trace_q <= cfg_data[0];
				end
				default: begin
					ring_size_q <= ring_size_q;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The table never holds more entries than it has slots.
	a_tcount: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= TCNT_W'(TABLE_DEPTH))
		else $error("page table fill count beyond depth");

	// The ring index never runs ahead of the filled part of the ring.
	a_ring_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(RCNT_W'(ring_index_q) <= ring_fill_q) && (ring_fill_q <= RCNT_W'(RING_DEPTH)))
		else $error("ring index beyond fill mark");

	// A probe sequence stays within one pass over the table.
	a_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOOK || state_q == S_EVLOOK) |->
		(probes_q != '0 && probes_q <= TCNT_W'(TABLE_DEPTH)))
		else $error("probe count out of range");

	// A finished word reaches the output and the sequencer returns to idle.
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && state_q == S_IDLE))
		else $error("result word not loaded");
`endif

endmodule

`default_nettype wire

### src/fwspt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module fwspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
